// ===== rtl/core/ttmp_pkg.sv =====
// ----------------------------------------------------------------------------
// ttmp_pkg
// Shared types and constants of the touch trimmed-mean to pixel converter.
// ----------------------------------------------------------------------------
package ttmp_pkg;

  localparam int SAMPLE_W             = 12;
  localparam int SUM_W                = 16;
  localparam int PROD_W               = 2 * SAMPLE_W;
  localparam int SAMPLES_PER_READ_DEF = 8;
  localparam int QUEUE_DEPTH_DEF      = 4;
  localparam int CFG_IDX_W            = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_X_RAW_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_RAW_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RAW_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RAW_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_H_RES     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_V_RES     = 3'd5;

  localparam logic [SAMPLE_W-1:0] RST_RAW_MIN = 12'd200;
  localparam logic [SAMPLE_W-1:0] RST_RAW_MAX = 12'd3900;
  localparam logic [SAMPLE_W-1:0] RST_H_RES   = 12'd320;
  localparam logic [SAMPLE_W-1:0] RST_V_RES   = 12'd240;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 12'hFFF;

  // burst order within one reading
  localparam logic [1:0] PH_X1 = 2'd0;
  localparam logic [1:0] PH_Y1 = 2'd1;
  localparam logic [1:0] PH_X2 = 2'd2;
  localparam logic [1:0] PH_Y2 = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x_raw_min;
    logic [SAMPLE_W-1:0] x_raw_max;
    logic [SAMPLE_W-1:0] y_raw_min;
    logic [SAMPLE_W-1:0] y_raw_max;
    logic [SAMPLE_W-1:0] h_res;
    logic [SAMPLE_W-1:0] v_res;
  } ttmp_cfg_t;

  // one queued job: a finished burst or a pen release
  typedef struct packed {
    logic             pen;
    logic [1:0]       phase;
    logic [SUM_W-1:0] diff;
  } ttmp_job_t;

  typedef struct packed {
    logic                start;
    logic [PROD_W-1:0]   dividend;
    logic [SAMPLE_W-1:0] divisor;
  } ttmp_div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } ttmp_div_rsp_t;

endpackage

// ===== rtl/core/ttmp_front.sv =====
// ----------------------------------------------------------------------------
// ttmp_front
// Takes samples, keeps running sum, min and max of the burst, and queues
// the trimmed sum of each finished burst or a pen release.
// ----------------------------------------------------------------------------
module ttmp_front import ttmp_pkg::*; #(
  parameter int SAMPLES_PER_READ = SAMPLES_PER_READ_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_pen_up,
  output logic                push_en,
  output ttmp_job_t           push_job,
  input  logic                q_full
);

  localparam int CNT_W = $clog2(SAMPLES_PER_READ);

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] min_r, min_nxt;
  logic [SAMPLE_W-1:0] max_r, max_nxt;

  logic                last;
  logic                accept;
  logic [SUM_W-1:0]    sum_add;
  logic [SAMPLE_W-1:0] min_new;
  logic [SAMPLE_W-1:0] max_new;

  assign last     = (cnt_r == CNT_W'(SAMPLES_PER_READ - 1));
  // only items that push need a free queue slot
  assign in_stall = q_full && (in_pen_up || last);
  assign accept   = in_valid && !in_stall;

  assign sum_add = sum_r + SUM_W'(in_sample);
  assign min_new = (in_sample < min_r) ? in_sample : min_r;
  assign max_new = (in_sample > max_r) ? in_sample : max_r;

  always_comb begin
    cnt_nxt        = cnt_r;
    phase_nxt      = phase_r;
    sum_nxt        = sum_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    push_en        = 1'b0;
    push_job.pen   = 1'b0;
    push_job.phase = phase_r;
    push_job.diff  = sum_add - SUM_W'(min_new) - SUM_W'(max_new);
    if (accept) begin
      if (in_pen_up) begin
        push_en      = 1'b1;
        push_job.pen = 1'b1;
        cnt_nxt      = '0;
        phase_nxt    = PH_X1;
        sum_nxt      = '0;
        min_nxt      = SAMPLE_MAX;
        max_nxt      = '0;
      end else if (last) begin
        push_en   = 1'b1;
        cnt_nxt   = '0;
        phase_nxt = phase_r + 2'd1;
        sum_nxt   = '0;
        min_nxt   = SAMPLE_MAX;
        max_nxt   = '0;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
        sum_nxt = sum_add;
        min_nxt = min_new;
        max_nxt = max_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      phase_r <= PH_X1;
      sum_r   <= '0;
      min_r   <= SAMPLE_MAX;
      max_r   <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

endmodule

// ===== rtl/core/ttmp_queue.sv =====
// ----------------------------------------------------------------------------
// ttmp_queue
// Short first-in first-out queue of jobs between front and back.
// ----------------------------------------------------------------------------
module ttmp_queue import ttmp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ttmp_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output ttmp_job_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ttmp_job_t        entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/ttmp_divider.sv =====
// ----------------------------------------------------------------------------
// ttmp_divider
// Restoring divider, one quotient bit per cycle, used by the pixel mapping
// of both axes.
// ----------------------------------------------------------------------------
module ttmp_divider import ttmp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  ttmp_div_req_t req,
  output ttmp_div_rsp_t rsp
);

  localparam int CNT_W = $clog2(PROD_W);

  logic [PROD_W-1:0]   quo_r;
  logic [SAMPLE_W-1:0] rem_r;
  logic [SAMPLE_W-1:0] dsr_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [SAMPLE_W:0]   partial;
  logic                fits;
  logic [SAMPLE_W:0]   trial;

  assign partial = {rem_r, quo_r[PROD_W-1]};
  assign fits    = (partial >= {1'b0, dsr_r});
  assign trial   = partial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[PROD_W-2:0], fits};
      rem_r <= fits ? trial[SAMPLE_W-1:0] : partial[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(PROD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/core/ttmp_back.sv =====
// ----------------------------------------------------------------------------
// ttmp_back
// Turns queued jobs into burst means, averages the two readings of each
// axis, checks raw windows and maps to pixels, or reports a pen release.
// ----------------------------------------------------------------------------
module ttmp_back import ttmp_pkg::*; #(
  parameter int SAMPLES_PER_READ = SAMPLES_PER_READ_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ttmp_cfg_t           cfg,
  input  logic                q_empty,
  input  ttmp_job_t           q_head,
  output logic                q_pop,
  output ttmp_div_req_t       div_req,
  input  ttmp_div_rsp_t       div_rsp,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_x_pixel,
  output logic [SAMPLE_W-1:0] out_y_pixel,
  output logic                out_touch_valid
);

  localparam int TRIM_DIV   = SAMPLES_PER_READ - 2;
  // floor(d / TRIM_DIV) is (d * RECIP) >> MEAN_SHIFT for every SUM_W-bit d
  localparam int MEAN_SHIFT = SUM_W + $clog2(TRIM_DIV);
  localparam int RECIP_W    = MEAN_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << MEAN_SHIFT) + TRIM_DIV - 1) / TRIM_DIV);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_WAIT_M  = 3'd1;
  localparam logic [2:0] S_START_X = 3'd2;
  localparam logic [2:0] S_WAIT_X  = 3'd3;
  localparam logic [2:0] S_START_Y = 3'd4;
  localparam logic [2:0] S_WAIT_Y  = 3'd5;
  localparam logic [2:0] S_EMIT    = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          phase_r;
  logic [SAMPLE_W-1:0] burst_mean_r;
  logic [SAMPLE_W-1:0] fx_r, fy_r, sx_r;
  logic [SAMPLE_W-1:0] xa_r, ya_r;
  logic                okx_r, oky_r;
  logic [SAMPLE_W-1:0] xpix_r, ypix_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_x_r, out_y_r;
  logic                out_ok_r;

  logic [SUM_W+RECIP_W-1:0] mean_prod;
  logic [SAMPLE_W-1:0]      mean;
  logic [SAMPLE_W:0]        xsum, ysum;
  logic [SAMPLE_W-1:0]      xa, ya;
  logic [SAMPLE_W-1:0]      xoff, yoff;
  logic                     emit_ok;
  logic                     ok_both;

  assign mean_prod = {{RECIP_W{1'b0}}, q_head.diff} * {{SUM_W{1'b0}}, RECIP};
  assign mean      = div_rsp.quotient[SAMPLE_W-1:0];
  assign xsum      = {1'b0, fx_r} + {1'b0, sx_r};
  assign ysum      = {1'b0, fy_r} + {1'b0, burst_mean_r};
  assign xa        = xsum[SAMPLE_W:1];
  assign ya        = ysum[SAMPLE_W:1];
  assign xoff      = xa_r - cfg.x_raw_min;
  assign yoff      = ya_r - cfg.y_raw_min;
  assign emit_ok   = !out_valid_r || !out_stall;
  assign ok_both   = okx_r && oky_r;

  always_comb begin
    state_nxt        = state_r;
    q_pop            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.pen) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_WAIT_M;
          end
        end
      end
      S_WAIT_M: begin
        // burst mean is registered, file it by phase
        state_nxt = (phase_r == PH_Y2) ? S_START_X : S_IDLE;
      end
      S_START_X: begin
        // product goes straight into the divider's dividend register
        div_req.start    = 1'b1;
        div_req.dividend = PROD_W'(xoff) * PROD_W'(cfg.h_res);
        div_req.divisor  = cfg.x_raw_max - cfg.x_raw_min;
        state_nxt        = S_WAIT_X;
      end
      S_WAIT_X: begin
        if (div_rsp.done) begin
          state_nxt = S_START_Y;
        end
      end
      S_START_Y: begin
        div_req.start    = 1'b1;
        div_req.dividend = PROD_W'(yoff) * PROD_W'(cfg.v_res);
        div_req.divisor  = cfg.y_raw_max - cfg.y_raw_min;
        state_nxt        = S_WAIT_Y;
      end
      S_WAIT_Y: begin
        if (div_rsp.done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EMIT && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && !q_empty) begin
      phase_r      <= q_head.phase;
      burst_mean_r <= mean_prod[MEAN_SHIFT +: SAMPLE_W];
      if (q_head.pen) begin
        okx_r <= 1'b0;
        oky_r <= 1'b0;
      end
    end
    if (state_r == S_WAIT_M) begin
      case (phase_r)
        PH_X1: fx_r <= burst_mean_r;
        PH_Y1: fy_r <= burst_mean_r;
        PH_X2: sx_r <= burst_mean_r;
        default: begin
          xa_r  <= xa;
          ya_r  <= ya;
          okx_r <= (cfg.x_raw_max > cfg.x_raw_min) && (xa <= cfg.x_raw_max) &&
                   (xa >= cfg.x_raw_min);
          oky_r <= (cfg.y_raw_max > cfg.y_raw_min) && (ya <= cfg.y_raw_max) &&
                   (ya >= cfg.y_raw_min);
        end
      endcase
    end
    if (state_r == S_WAIT_X && div_rsp.done) begin
      xpix_r <= cfg.h_res - mean;
    end
    if (state_r == S_WAIT_Y && div_rsp.done) begin
      ypix_r <= cfg.v_res - mean;
    end
    if (state_r == S_EMIT && emit_ok) begin
      out_ok_r <= ok_both;
      out_x_r  <= ok_both ? xpix_r : '0;
      out_y_r  <= ok_both ? ypix_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x_pixel     = out_x_r;
  assign out_y_pixel     = out_y_r;
  assign out_touch_valid = out_ok_r;

endmodule

// ===== rtl/core/touch_trimmed_mean_to_pixel.sv =====
// ----------------------------------------------------------------------------
// touch_trimmed_mean_to_pixel
// Reduces four bursts of touch samples (X, Y, X, Y) to trimmed means and
// maps the averaged position to display pixels.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_sample, in_pen_up
//   out_     output     out_valid/out_stall  out_x_pixel, out_y_pixel,
//                                            out_touch_valid
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a sample is taken whenever in_stall is low
// a finished burst passes the back end in S_IDLE and S_WAIT_M (mean by
// reciprocal multiply); the last burst of a reading then goes on through
// S_START_X, S_WAIT_X, S_START_Y and S_WAIT_Y (two divisions in the divider)
// and S_EMIT to the output; a pen release goes from S_IDLE to S_EMIT
// the front stalls only when a burst end or pen release meets a full queue
// synchronous reset clears control state; configuration returns to defaults
// ----------------------------------------------------------------------------
module touch_trimmed_mean_to_pixel import ttmp_pkg::*; #(
  parameter int SAMPLES_PER_READ = SAMPLES_PER_READ_DEF,
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  in_sample,
  input  logic                 in_pen_up,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SAMPLE_W-1:0]  out_x_pixel,
  output logic [SAMPLE_W-1:0]  out_y_pixel,
  output logic                 out_touch_valid,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data
);

  ttmp_cfg_t     cfg_r;
  ttmp_job_t     push_job, q_head;
  logic          push_en, q_full, q_empty, q_pop;
  ttmp_div_req_t div_req;
  ttmp_div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_raw_min <= RST_RAW_MIN;
      cfg_r.x_raw_max <= RST_RAW_MAX;
      cfg_r.y_raw_min <= RST_RAW_MIN;
      cfg_r.y_raw_max <= RST_RAW_MAX;
      cfg_r.h_res     <= RST_H_RES;
      cfg_r.v_res     <= RST_V_RES;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_X_RAW_MIN: cfg_r.x_raw_min <= cfg_data;
        CFG_X_RAW_MAX: cfg_r.x_raw_max <= cfg_data;
        CFG_Y_RAW_MIN: cfg_r.y_raw_min <= cfg_data;
        CFG_Y_RAW_MAX: cfg_r.y_raw_max <= cfg_data;
        CFG_H_RES:     cfg_r.h_res     <= cfg_data;
        CFG_V_RES:     cfg_r.v_res     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ttmp_front #(
    .SAMPLES_PER_READ(SAMPLES_PER_READ)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_sample(in_sample),
    .in_pen_up(in_pen_up),
    .push_en  (push_en),
    .push_job (push_job),
    .q_full   (q_full)
  );

  ttmp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push_en),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (q_head)
  );

  ttmp_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  ttmp_back #(
    .SAMPLES_PER_READ(SAMPLES_PER_READ)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x_pixel    (out_x_pixel),
    .out_y_pixel    (out_y_pixel),
    .out_touch_valid(out_touch_valid)
  );

endmodule

// ===== rtl/core/ttmp_checker.sv =====
// ----------------------------------------------------------------------------
// ttmp_checker
// Port-level checks of the touch converter, bound to the top level.
// ----------------------------------------------------------------------------
module ttmp_checker import ttmp_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [SAMPLE_W-1:0]  in_sample,
  input logic                 in_pen_up,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [SAMPLE_W-1:0]  out_x_pixel,
  input logic [SAMPLE_W-1:0]  out_y_pixel,
  input logic                 out_touch_valid
);

  // an invalid touch carries zero coordinates
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_touch_valid |-> out_x_pixel == '0 && out_y_pixel == '0)
    else $error("invalid touch with nonzero pixel");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_x_pixel) && $stable(out_y_pixel) &&
      $stable(out_touch_valid))
    else $error("result changed while stalled");

  // a stalled input item holds still
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_sample) && $stable(in_pen_up))
    else $error("input item changed while stalled");

endmodule

bind touch_trimmed_mean_to_pixel ttmp_checker u_checker (.*);
